### hdl/ccs_pkg.sv
package ccs_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  typedef enum logic [5:0] {
    MODE_CODE  = 6'b000001,
    MODE_STR   = 6'b000010,
    MODE_CHR   = 6'b000100,
    MODE_LINE  = 6'b001000,
    MODE_BLOCK = 6'b010000,
    MODE_BSTAR = 6'b100000
  } lex_mode_t;

  // bytes produced by one input word, plus its end mark
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] cnt;
    logic       last;
  } ccs_op_t;

endpackage

### hdl/ccs_in_if.sv
interface ccs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

### hdl/ccs_out_if.sv
interface ccs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_end;
  logic       stream_end;

  modport source (output valid, output out_byte, output byte_valid, output run_end,
                  output stream_end, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input run_end,
                input stream_end, output ready);
endinterface

### hdl/ccs_front.sv
module ccs_front import ccs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ccs_in_if.sink      in_ch,
  input  logic        full,
  output logic        push,
  output ccs_op_t     op
);

  lex_mode_t  mode, mode_next;
  logic       esc, esc_next;
  logic       held, held_next;
  logic       acc;
  logic [7:0] b;

  assign in_ch.ready = !full;
  assign acc = in_ch.valid && !full;
  assign b = in_ch.in_byte;

  always_comb begin
    mode_next = mode;
    esc_next  = esc;
    held_next = held;
    op.b0 = '0;
    op.b1 = '0;
    op.cnt = 2'd0;
    op.last = in_ch.in_last;
    case (mode)
      MODE_STR, MODE_CHR: begin
        op.b0 = b;
        op.cnt = 2'd1;
        if (esc) begin
          esc_next = 1'b0;
        end else if (b == CH_BSL) begin
          esc_next = 1'b1;
        end else if ((mode == MODE_STR && b == CH_DQ) || (mode == MODE_CHR && b == CH_SQ)) begin
          mode_next = MODE_CODE;
        end
      end
      MODE_LINE: begin
        if (b == CH_NL) begin
          mode_next = MODE_CODE;
          op.b0 = b;
          op.cnt = 2'd1;
        end
      end
      MODE_BLOCK: begin
        if (b == CH_STAR) mode_next = MODE_BSTAR;
      end
      MODE_BSTAR: begin
        if (b == CH_SLASH) begin
          mode_next = MODE_CODE;
        end else if (b != CH_STAR) begin
          mode_next = MODE_BLOCK;
        end
      end
      default: begin
        mode_next = MODE_CODE;
        if (held && b == CH_SLASH) begin
          held_next = 1'b0;
          mode_next = MODE_LINE;
        end else if (held && b == CH_STAR) begin
          held_next = 1'b0;
          mode_next = MODE_BLOCK;
        end else begin
          // held slash that opens nothing goes out ahead of this byte
          if (held) begin
            held_next = 1'b0;
            op.b0 = CH_SLASH;
            op.cnt = 2'd1;
          end
          if (esc) begin
            esc_next = 1'b0;
          end else if (b == CH_BSL) begin
            esc_next = 1'b1;
          end else if (b == CH_DQ) begin
            mode_next = MODE_STR;
          end else if (b == CH_SQ) begin
            mode_next = MODE_CHR;
          end
          if (b == CH_SLASH) begin
            held_next = 1'b1;
          end else if (op.cnt == 2'd0) begin
            op.b0 = b;
            op.cnt = 2'd1;
          end else begin
            op.b1 = b;
            op.cnt = 2'd2;
          end
        end
      end
    endcase
    // flush a slash still held at the end of the text
    if (in_ch.in_last && held_next) begin
      if (op.cnt == 2'd0) begin
        op.b0 = CH_SLASH;
        op.cnt = 2'd1;
      end else begin
        op.b1 = CH_SLASH;
        op.cnt = 2'd2;
      end
    end
    if (in_ch.in_last) begin
      mode_next = MODE_CODE;
      esc_next  = 1'b0;
      held_next = 1'b0;
    end
  end

  assign push = acc && (op.cnt != 2'd0 || op.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_CODE;
      esc  <= 1'b0;
      held <= 1'b0;
    end else if (acc) begin
      mode <= mode_next;
      esc  <= esc_next;
      held <= held_next;
    end
  end

`ifndef SYNTHESIS
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (acc && in_ch.in_last) |=> (mode == MODE_CODE && !esc && !held))
    else $error("lexer state not cleared after last word");

  a_held_in_code: assert property (@(posedge clk) disable iff (rst)
    held |-> (mode == MODE_CODE))
    else $error("slash held outside code");
`endif

endmodule

### hdl/ccs_fifo.sv
module ccs_fifo import ccs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  ccs_op_t wdata,
  output logic    full,
  output logic    nonempty,
  input  logic    pop,
  output ccs_op_t rdata
);

  ccs_op_t            mem [QDepth];
  logic [QAw-1:0]     wptr;
  logic [QAw-1:0]     rptr;
  logic [QAw:0]       count;

  assign full = (count == (QAw+1)'(QDepth));
  assign nonempty = (count != '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue read while empty");
`endif

endmodule

### hdl/ccs_back.sv
module ccs_back import ccs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        nonempty,
  input  ccs_op_t     head,
  output logic        pop,
  ccs_out_if.source   out_ch
);

  logic       ovalid;
  logic [7:0] obyte;
  logic       obyte_valid, orun_end, ostream_end;
  logic       second;        // second byte of the popped entry still to go
  logic [7:0] second_byte;
  logic       second_last;
  logic       load;

  assign load = !ovalid || out_ch.ready;
  assign pop  = load && !second && nonempty;

  assign out_ch.valid      = ovalid;
  assign out_ch.out_byte   = obyte;
  assign out_ch.byte_valid = obyte_valid;
  assign out_ch.run_end    = orun_end;
  assign out_ch.stream_end = ostream_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      second <= 1'b0;
    end else if (load) begin
      if (second) begin
        ovalid <= 1'b1;
        second <= 1'b0;
      end else begin
        ovalid <= nonempty;
        second <= nonempty && (head.cnt == 2'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second) begin
        obyte       <= second_byte;
        obyte_valid <= 1'b1;
        orun_end    <= 1'b1;
        ostream_end <= second_last;
      end else begin
        obyte       <= (head.cnt == 2'd0) ? 8'h00 : head.b0;
        obyte_valid <= (head.cnt != 2'd0);
        orun_end    <= (head.cnt != 2'd2);
        ostream_end <= head.last && (head.cnt != 2'd2);
        second_byte <= head.b1;
        second_last <= head.last;
      end
    end
  end

`ifndef SYNTHESIS
  a_second_behind_word: assert property (@(posedge clk) disable iff (rst)
    second |-> ovalid)
    else $error("second byte pending with no word shown");
`endif

endmodule

### hdl/c_comment_stripper.sv
// Strips C comments from a byte stream: every source byte outside a line or block
// comment is passed on, with string literals, character constants and backslash
// escapes tracked so comment markers inside them are kept. A slash in code is held
// until the next byte shows whether it opens a comment. The input word marked last
// ends the text: a held slash is flushed, the final output word carries stream_end,
// and if no byte results an end-only word (byte_valid low) is given. The
// combinational lexer takes one input word per clock into a 4-entry queue, unless
// the queue is full; the output side sends one word per clock while out_ch.ready is
// high; an input yielding two bytes (held slash plus next byte) gives two words.
module c_comment_stripper import ccs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ccs_in_if.sink    in_ch,
  ccs_out_if.source out_ch
);

  logic    push, full, nonempty, pop;
  ccs_op_t op, head;

  ccs_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .op    (op)
  );

  ccs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (op),
    .full     (full),
    .nonempty (nonempty),
    .pop      (pop),
    .rdata    (head)
  );

  ccs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
